// ===== hw/rtl/bfie_pkg.sv =====
// Shared types, codes and sizes of the instruction engine.
package bfie_pkg;

  localparam int unsigned PROGRAM_DEPTH    = 4096;
  localparam int unsigned TAPE_DEPTH       = 32768;
  localparam int unsigned LOOP_STACK_DEPTH = 64;

  localparam int unsigned PC_W   = 13;
  localparam int unsigned PA_W   = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned FUNC_W = 2;

  // Item functions
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_RUN       = 3'd0;
  localparam logic [STAT_W-1:0] ST_END       = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNMATCHED = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd4;

  // Command characters
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PA_W-1:0]   load_address;
    logic [BYTE_W-1:0] load_character;
    logic [BYTE_W-1:0] input_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] output_byte;
    logic              output_valid;
    logic              input_consumed;
    logic [STAT_W-1:0] status;
    logic [PC_W-1:0]   program_counter;
  } out_t;

endpackage

// ===== hw/rtl/bfie_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface bfie_in_if;
  logic           valid;
  logic           ready;
  bfie_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfie_out_if;
  logic           valid;
  logic           ready;
  bfie_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bfie_ram.sv =====
// Generic RAM with one write port and one registered read port.
module bfie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bfie_alu.sv =====
// Shared increment/decrement unit with a less-than compare.
module bfie_alu #(
  parameter int unsigned W = 16
) (
  input  logic [W-1:0] a_i,
  input  logic         dec_i,
  input  logic [W-1:0] b_i,
  input  logic         cmp_sum_i,
  output logic [W-1:0] sum_o,
  output logic         lt_o
);

  logic [W-1:0] lhs;

  // Step by one in either direction
  assign sum_o = dec_i ? (a_i - W'(1)) : (a_i + W'(1));

  // Compare the operand or the stepped value against the bound
  assign lhs  = cmp_sum_i ? sum_o : a_i;
  assign lt_o = (lhs < b_i);

endmodule

// ===== hw/rtl/brainfuck_instruction_engine_unit.sv =====
// Instruction engine top level: sequencer, shared unit and the three stores.
// Load, unused and refused steps go from accept straight to the result state; a step
// fetches, advances and reports, skips the advance on a stack error, pops first for a
// taken ']', and a forward '[' scan walks the program one character at a time. Restart
// clears the whole tape before its result. Reset: asynchronous; afterwards the whole
// tape is cleared with no item taken. One item is in work at a time.
module brainfuck_instruction_engine_unit #(
  parameter int unsigned TAPE_DEPTH       = bfie_pkg::TAPE_DEPTH,
  parameter int unsigned LOOP_STACK_DEPTH = bfie_pkg::LOOP_STACK_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bfie_pkg::PC_W-1:0] cfg_data_i,
  bfie_in_if.sink                   in_i,
  bfie_out_if.source                out_o
);

  localparam int unsigned HW  = $clog2(TAPE_DEPTH);
  localparam int unsigned SW  = $clog2(LOOP_STACK_DEPTH);
  localparam int unsigned DW  = $clog2(LOOP_STACK_DEPTH + 1);
  localparam int unsigned PCW = bfie_pkg::PC_W;
  localparam int unsigned AW  = (HW > PCW) ? HW : PCW;
  localparam int unsigned BW  = bfie_pkg::BYTE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_ADV   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SCHK  = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [PCW-1:0]                len_q, len_d, leff;
  logic [PCW-1:0]                pc_q, pc_d;
  logic [HW-1:0]                 head_q, head_d;
  logic [DW-1:0]                 sd_q, sd_d;
  logic [bfie_pkg::STAT_W-1:0]   err_q, err_d;
  logic [PCW-1:0]                base_q, base_d;
  logic [PCW-1:0]                idx_q, idx_d;
  logic [PCW-1:0]                bal_q, bal_d;
  logic [HW-1:0]                 clr_q, clr_d;
  logic                          restart_q, restart_d;
  logic [BW-1:0]                 ibyte_q, ibyte_d;
  logic [BW-1:0]                 obyte_q, obyte_d;
  logic                          oval_q, oval_d;
  logic                          icons_q, icons_d;
  logic                          out_valid_q, out_valid_d;
  bfie_pkg::out_t                out_data_q, out_data_d;

  // Shared unit operands
  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_dec, alu_cmp_sum, alu_lt;

  // Store ports
  logic                          prog_we;
  logic [bfie_pkg::PA_W-1:0]     prog_raddr;
  logic [BW-1:0]                 prog_rdata;
  logic                          tape_we;
  logic [HW-1:0]                 tape_waddr;
  logic [BW-1:0]                 tape_wdata, tape_rdata;
  logic                          stk_we;
  logic [SW-1:0]                 stk_raddr;
  logic [bfie_pkg::PA_W-1:0]     stk_rdata;

  logic out_free;

  assign leff = (len_q > PCW'(bfie_pkg::PROGRAM_DEPTH)) ? PCW'(bfie_pkg::PROGRAM_DEPTH) : len_q;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  bfie_alu #(.W(AW)) u_alu (
    .a_i      (alu_a),
    .dec_i    (alu_dec),
    .b_i      (alu_b),
    .cmp_sum_i(alu_cmp_sum),
    .sum_o    (alu_sum),
    .lt_o     (alu_lt)
  );

  bfie_ram #(.WIDTH(BW), .DEPTH(bfie_pkg::PROGRAM_DEPTH)) u_prog (
    .clk_i  (clk_i),
    .we_i   (prog_we),
    .waddr_i(in_i.data.load_address),
    .wdata_i(in_i.data.load_character),
    .raddr_i(prog_raddr),
    .rdata_o(prog_rdata)
  );

  bfie_ram #(.WIDTH(BW), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk_i  (clk_i),
    .we_i   (tape_we),
    .waddr_i(tape_waddr),
    .wdata_i(tape_wdata),
    .raddr_i(head_q),
    .rdata_o(tape_rdata)
  );

  bfie_ram #(.WIDTH(bfie_pkg::PA_W), .DEPTH(LOOP_STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(sd_q[SW-1:0]),
    .wdata_i(pc_q[bfie_pkg::PA_W-1:0]),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // Address the program store from the pc or the scan index
  assign prog_raddr = (state_q == S_SCAN) ? idx_q[bfie_pkg::PA_W-1:0]
                                          : pc_q[bfie_pkg::PA_W-1:0];
  assign stk_raddr  = SW'(sd_q - DW'(1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pc_d        = pc_q;
    head_d      = head_q;
    sd_d        = sd_q;
    err_d       = err_q;
    base_d      = base_q;
    idx_d       = idx_q;
    bal_d       = bal_q;
    clr_d       = clr_q;
    restart_d   = restart_q;
    ibyte_d     = ibyte_q;
    obyte_d     = obyte_q;
    oval_d      = oval_q;
    icons_d     = icons_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    alu_a       = AW'(pc_q);
    alu_b       = AW'(leff);
    alu_dec     = 1'b0;
    alu_cmp_sum = 1'b0;
    prog_we     = 1'b0;
    tape_we     = 1'b0;
    tape_waddr  = head_q;
    tape_wdata  = '0;
    stk_we      = 1'b0;

    // Drop the result once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      len_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          obyte_d = '0;
          oval_d  = 1'b0;
          icons_d = 1'b0;
          ibyte_d = in_i.data.input_byte;
          state_d = S_DONE;
          unique case (in_i.data.func)
            bfie_pkg::FUNC_LOAD: begin
              prog_we = 1'b1;
            end
            bfie_pkg::FUNC_STEP: begin
              if (err_q == bfie_pkg::ST_RUN) begin
                if (!alu_lt) begin
                  err_d = bfie_pkg::ST_END;
                end else begin
                  state_d = S_FETCH;
                end
              end
            end
            bfie_pkg::FUNC_RESTART: begin
              pc_d      = '0;
              head_d    = '0;
              sd_d      = '0;
              err_d     = bfie_pkg::ST_RUN;
              clr_d     = '0;
              restart_d = 1'b1;
              state_d   = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      S_FETCH: begin
        base_d  = pc_q;
        state_d = S_ADV;
        unique case (prog_rdata)
          bfie_pkg::CH_RIGHT: begin
            alu_a = AW'(head_q);
            if (head_q != HW'(TAPE_DEPTH - 1)) begin
              head_d = alu_sum[HW-1:0];
            end
          end
          bfie_pkg::CH_LEFT: begin
            alu_a   = AW'(head_q);
            alu_dec = 1'b1;
            if (head_q != '0) begin
              head_d = alu_sum[HW-1:0];
            end
          end
          bfie_pkg::CH_PLUS, bfie_pkg::CH_MINUS: begin
            alu_a      = AW'(tape_rdata);
            alu_dec    = (prog_rdata == bfie_pkg::CH_MINUS);
            tape_we    = 1'b1;
            tape_wdata = alu_sum[BW-1:0];
          end
          bfie_pkg::CH_DOT: begin
            obyte_d = tape_rdata;
            oval_d  = 1'b1;
          end
          bfie_pkg::CH_COMMA: begin
            tape_we    = 1'b1;
            tape_wdata = ibyte_q;
            icons_d    = 1'b1;
          end
          bfie_pkg::CH_OPEN: begin
            if (tape_rdata == '0) begin
              // Start a forward scan after the bracket
              idx_d   = alu_sum[PCW-1:0];
              bal_d   = PCW'(1);
              state_d = S_SCAN;
            end else if (sd_q >= DW'(LOOP_STACK_DEPTH)) begin
              err_d   = bfie_pkg::ST_OVERFLOW;
              state_d = S_DONE;
            end else begin
              stk_we = 1'b1;
              sd_d   = sd_q + DW'(1);
            end
          end
          bfie_pkg::CH_CLOSE: begin
            if (sd_q == '0) begin
              err_d   = bfie_pkg::ST_UNDERFLOW;
              state_d = S_DONE;
            end else if (tape_rdata != '0) begin
              state_d = S_POP;
            end else begin
              sd_d = sd_q - DW'(1);
            end
          end
          default: begin
          end
        endcase
      end

      S_POP: begin
        base_d  = PCW'(stk_rdata);
        state_d = S_ADV;
      end

      S_SCAN: begin
        alu_a = AW'(idx_q);
        if (!alu_lt) begin
          err_d   = bfie_pkg::ST_UNMATCHED;
          state_d = S_DONE;
        end else begin
          state_d = S_SCHK;
        end
      end

      S_SCHK: begin
        alu_a   = AW'(idx_q);
        idx_d   = alu_sum[PCW-1:0];
        state_d = S_SCAN;
        if (prog_rdata == bfie_pkg::CH_OPEN) begin
          bal_d = bal_q + PCW'(1);
        end else if (prog_rdata == bfie_pkg::CH_CLOSE) begin
          bal_d = bal_q - PCW'(1);
          if (bal_q == PCW'(1)) begin
            base_d  = idx_q;
            state_d = S_ADV;
          end
        end
      end

      S_ADV: begin
        // Advance past the base and check for the end of the program
        alu_a       = AW'(base_q);
        alu_cmp_sum = 1'b1;
        pc_d        = alu_sum[PCW-1:0];
        if (!alu_lt) begin
          err_d = bfie_pkg::ST_END;
        end
        state_d = S_DONE;
      end

      S_CLEAR: begin
        alu_a      = AW'(clr_q);
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        clr_d      = alu_sum[HW-1:0];
        if (clr_q == HW'(TAPE_DEPTH - 1)) begin
          state_d = restart_q ? S_DONE : S_IDLE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.output_byte     = obyte_q;
          out_data_d.output_valid    = oval_q;
          out_data_d.input_consumed  = icons_q;
          out_data_d.status          = err_q;
          out_data_d.program_counter = pc_q;
          restart_d                  = 1'b0;
          state_d                    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      len_q       <= '0;
      pc_q        <= '0;
      head_q      <= '0;
      sd_q        <= '0;
      err_q       <= bfie_pkg::ST_RUN;
      clr_q       <= '0;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pc_q        <= pc_d;
      head_q      <= head_d;
      sd_q        <= sd_d;
      err_q       <= err_d;
      clr_q       <= clr_d;
      restart_q   <= restart_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    idx_q      <= idx_d;
    bal_q      <= bal_d;
    ibyte_q    <= ibyte_d;
    obyte_q    <= obyte_d;
    oval_q     <= oval_d;
    icons_q    <= icons_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== hw/rtl/bfie_chk.sv =====
// Port checker for the instruction engine and its bind.
module bfie_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_ovalid_i,
  input logic       out_icons_i
);

  // Hold the result while the sink stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Take one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while busy");

  // Emit no byte without an output command
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ovalid_i |-> out_byte_i == 8'd0)
    else $error("stray output byte");

  // Never both emit and consume in one step
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_ovalid_i && out_icons_i))
    else $error("output and input in one step");

endmodule

bind brainfuck_instruction_engine_unit bfie_chk u_bfie_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.data.output_byte),
  .out_ovalid_i(out_o.data.output_valid),
  .out_icons_i (out_o.data.input_consumed)
);
